>>> src/pkrf_pkg.sv
// shared types and constants of the per-key rate filter with lockout
// no dependencies
package pkrf_pkg;

  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [KEY_W-1:0] NO_KEY = {KEY_W{1'b1}};

  localparam logic [TICK_W-1:0]  SPACE_TICKS_RST = TICK_W'(10);
  localparam logic [TICK_W-1:0]  KEEP_TICKS_RST  = TICK_W'(100);
  localparam logic [TICK_W-1:0]  LOCK_TICKS_RST  = TICK_W'(300);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = COUNT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_CODE_0 = 4'd0,
    REG_KEY_CODE_1 = 4'd1,
    REG_KEY_CODE_2 = 4'd2,
    REG_KEY_CODE_3 = 4'd3,
    REG_SPACE      = 4'd4,
    REG_KEEP       = 4'd5,
    REG_LOCK       = 4'd6,
    REG_LIMIT      = 4'd7
  } pkrf_reg_e;

  // travels along the row of key cells
  typedef struct packed {
    logic found;    // an earlier slot already matched the key
    logic all_sat;  // every slot so far is saturated
    logic pass;     // the matching slot passed its spacing check
  } pkrf_chain_t;

  localparam pkrf_chain_t CHAIN_HEAD = '{found: 1'b0, all_sat: 1'b1, pass: 1'b0};

  // decision of the lockout controller for one tick
  typedef struct packed {
    logic accepted;
    logic busy_start;
    logic busy_end;
  } pkrf_result_t;

endpackage

>>> src/pkrf_ifs.sv
// valid/ready channel interfaces of the rate filter: input, result, config
// depends on pkrf_pkg
interface pkrf_in_if import pkrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_value;
  modport source (output valid, output key_value, input ready);
  modport sink   (input valid, input key_value, output ready);
endinterface

interface pkrf_out_if import pkrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [KEY_W-1:0] key_out;
  logic             busy_start;
  logic             busy_end;
  modport source (output valid, output accepted, output key_out, output busy_start,
                  output busy_end, input ready);
  modport sink   (input valid, input accepted, input key_out, input busy_start,
                  input busy_end, output ready);
endinterface

interface pkrf_cfg_if import pkrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/pkrf_cell.sv
// one key slot: key code register, spacing counter and its link in the chain
// depends on pkrf_pkg
module pkrf_cell import pkrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              code_we_i,
  input  logic [KEY_W-1:0]  code_data_i,
  input  logic              step_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [TICK_W-1:0] space_ticks_i,
  input  logic [TICK_W-1:0] keep_ticks_i,
  input  pkrf_chain_t       chain_i,
  output pkrf_chain_t       chain_o
);

  logic [KEY_W-1:0]  code_q;
  logic [TICK_W-1:0] cnt_q, cnt_d;
  logic [TICK_W-1:0] adv;
  logic              sat, match, hit, pass;

  always_comb begin
    sat   = (cnt_q >= keep_ticks_i);
    adv   = sat ? keep_ticks_i : cnt_q + TICK_W'(1);
    match = (key_i != NO_KEY) && (code_q == key_i);
    hit   = match && !chain_i.found;
    pass  = hit && (adv > space_ticks_i);
    cnt_d = pass ? '0 : adv;
    chain_o.found   = chain_i.found | match;
    chain_o.all_sat = chain_i.all_sat & sat;
    chain_o.pass    = chain_i.pass | pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= NO_KEY;
      cnt_q  <= '0;
    end else begin
      if (code_we_i) begin
        code_q <= code_data_i;
      end
      if (step_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

>>> src/pkrf_lock.sv
// press counter and busy lockout sequencer
// depends on pkrf_pkg
module pkrf_lock import pkrf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pkrf_chain_t        chain_i,
  input  logic [COUNT_W-1:0] count_limit_i,
  input  logic [TICK_W-1:0]  lock_ticks_i,
  output logic               locked_o,
  output pkrf_result_t       result_o
);

  logic               locked_q, locked_d;
  logic [COUNT_W-1:0] press_q, press_d, press_base;
  logic [TICK_W-1:0]  lcnt_q, lcnt_d;
  logic [COUNT_W:0]   press_next;
  logic [TICK_W:0]    lcnt_next;

  always_comb begin
    locked_d   = locked_q;
    press_d    = press_q;
    lcnt_d     = lcnt_q;
    result_o   = '0;
    press_base = chain_i.all_sat ? '0 : press_q;
    press_next = {1'b0, press_base} + (COUNT_W+1)'(1);
    lcnt_next  = {1'b0, lcnt_q} + (TICK_W+1)'(1);
    if (!locked_q) begin
      press_d = press_base;
      if (chain_i.pass) begin
        if (press_next > {1'b0, count_limit_i}) begin
          press_d             = '0;
          locked_d            = 1'b1;
          lcnt_d              = '0;
          result_o.busy_start = 1'b1;
        end else begin
          press_d           = press_next[COUNT_W-1:0];
          result_o.accepted = 1'b1;
        end
      end
    end else begin
      if (lcnt_next > {1'b0, lock_ticks_i}) begin
        locked_d          = 1'b0;
        lcnt_d            = '0;
        result_o.busy_end = 1'b1;
      end else begin
        lcnt_d = lcnt_next[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      press_q  <= '0;
      lcnt_q   <= '0;
    end else if (step_i) begin
      locked_q <= locked_d;
      press_q  <= press_d;
      lcnt_q   <= lcnt_d;
    end
  end

  assign locked_o = locked_q;

endmodule

>>> src/per_key_rate_filter_with_lockout.sv
// top level of the per-key rate filter with busy lockout
// depends on pkrf_pkg, pkrf_ifs, pkrf_cell and pkrf_lock
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid / ready | key_value
//   out_o   | out | valid / ready | accepted, key_out, busy_start, busy_end
//   cfg_i   | in  | valid / ready | index, data
//
// one item per cycle: a tick walks the row of key cells and the lockout
// sequencer in the cycle it is accepted, and its result is captured in the
// output register at the end of that cycle. the output register is the only
// stall point: a new item is taken whenever it is empty or being drained in
// the same cycle. reset clears all counters, unlocks, and loads the register
// defaults. config writes are always taken, one per cycle.
module per_key_rate_filter_with_lockout import pkrf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  pkrf_in_if.sink    in_i,
  pkrf_out_if.source out_o,
  pkrf_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [TICK_W-1:0]  space_q, keep_q, lock_q;
  logic [COUNT_W-1:0] limit_q;
  logic               cfg_acc;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q <= SPACE_TICKS_RST;
      keep_q  <= KEEP_TICKS_RST;
      lock_q  <= LOCK_TICKS_RST;
      limit_q <= COUNT_LIMIT_RST;
    end else if (cfg_acc) begin
      case (pkrf_reg_e'(cfg_i.index))
        REG_SPACE: space_q <= cfg_i.data[TICK_W-1:0];
        REG_KEEP:  keep_q  <= cfg_i.data[TICK_W-1:0];
        REG_LOCK:  lock_q  <= cfg_i.data[TICK_W-1:0];
        REG_LIMIT: limit_q <= cfg_i.data[COUNT_W-1:0];
        default:   ;  // key codes live in the cells, other indexes are dropped
      endcase
    end
  end

  // input acceptance, gated only by the output register
  logic in_acc, out_valid_q, locked, step_cells;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign step_cells = in_acc && !locked;  // spacing counters hold while locked

  // row of key cells, slot 0 first so the lowest matching slot wins
  pkrf_chain_t      chain [NUM_KEYS+1];
  logic [NUM_KEYS-1:0] code_we;

  assign chain[0] = CHAIN_HEAD;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
    // key code registers take indexes from key_code_0 upward
    assign code_we[g] = cfg_acc &&
                        (cfg_i.index == CFG_IDX_W'(int'(REG_KEY_CODE_0) + g));

    pkrf_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .code_we_i     (code_we[g]),
      .code_data_i   (cfg_i.data[KEY_W-1:0]),
      .step_i        (step_cells),
      .key_i         (in_i.key_value),
      .space_ticks_i (space_q),
      .keep_ticks_i  (keep_q),
      .chain_i       (chain[g]),
      .chain_o       (chain[g+1])
    );
  end

  // press counting and lockout
  pkrf_result_t res;

  pkrf_lock u_lock (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_acc),
    .chain_i       (chain[NUM_KEYS]),
    .count_limit_i (limit_q),
    .lock_ticks_i  (lock_q),
    .locked_o      (locked),
    .result_o      (res)
  );

  // output register
  logic             acc_q, bstart_q, bend_q;
  logic [KEY_W-1:0] kout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q    <= res.accepted;
      kout_q   <= res.accepted ? in_i.key_value : NO_KEY;
      bstart_q <= res.busy_start;
      bend_q   <= res.busy_end;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.accepted   = acc_q;
  assign out_o.key_out    = kout_q;
  assign out_o.busy_start = bstart_q;
  assign out_o.busy_end   = bend_q;

`ifndef SYNTH
  // a tick taken while locked never yields a press or a new lockout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && locked) |=> (out_o.valid && !out_o.accepted && !out_o.busy_start))
    else $error("locked tick produced a press or busy start");

  // a visible busy start means the sequencer is locked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.busy_start) |-> locked)
    else $error("busy start shown while unlocked");

  // a rejected item always carries the no-key code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.accepted) |-> (out_o.key_out == NO_KEY))
    else $error("rejected item carries a key value");

  // unlocking is reported exactly once, on a tick taken while locked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.busy_end) |=> !locked)
    else $error("busy end without unlock");
`endif

endmodule

>>> tb/testbench.sv
// self-checking testbench of the per-key rate filter with lockout
// depends on pkrf_pkg, the channel interfaces in pkrf_ifs and the top level
module testbench;
  import pkrf_pkg::*;

  // one result of the filter, as the output channel carries it
  typedef struct packed {
    logic             accepted;
    logic [KEY_W-1:0] key_out;
    logic             busy_start;
    logic             busy_end;
  } tick_res_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // one line of the directed part: a tick or a register write
  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [KEY_W-1:0]     value;
    bit                   typed;
    tick_res_t            want;
  } row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  localparam tick_res_t QUIET     = '{1'b0, NO_KEY, 1'b0, 1'b0};
  localparam tick_res_t LOCK_BEG  = '{1'b0, NO_KEY, 1'b1, 1'b0};
  localparam tick_res_t LOCK_DONE = '{1'b0, NO_KEY, 1'b0, 1'b1};

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = CFG_IDX_W'(15);

  localparam logic [KEY_W-1:0] KEY_A = 32'hA5A5_A5A5;

  logic  clk_i;
  logic  rst_ni;
  bit    failed;
  idle_e idle_mode;

  pkrf_in_if  tick_ch ();
  pkrf_out_if res_ch ();
  pkrf_cfg_if reg_ch ();

  per_key_rate_filter_with_lockout dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tick_ch),
    .out_o (res_ch),
    .cfg_i (reg_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and the filter state
  logic [KEY_W-1:0]   m_code [NUM_KEYS];
  logic [TICK_W-1:0]  m_space;
  logic [TICK_W-1:0]  m_keep;
  logic [TICK_W-1:0]  m_lock;
  logic [COUNT_W-1:0] m_limit;
  logic [TICK_W-1:0]  m_spc [NUM_KEYS];
  logic [COUNT_W-1:0] m_press;
  logic               m_locked;
  logic [TICK_W-1:0]  m_lock_cnt;

  tick_res_t tick_exp_q [$];
  row_t      dir_tab [$];

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_KEY_CODE_0: m_code[0] = val;
      REG_KEY_CODE_1: m_code[1] = val;
      REG_KEY_CODE_2: m_code[2] = val;
      REG_KEY_CODE_3: m_code[3] = val;
      REG_SPACE:      m_space   = val[TICK_W-1:0];
      REG_KEEP:       m_keep    = val[TICK_W-1:0];
      REG_LOCK:       m_lock    = val[TICK_W-1:0];
      REG_LIMIT:      m_limit   = val[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // advances the filter by one poll tick and returns what it should emit
  function automatic tick_res_t filter_tick(input logic [KEY_W-1:0] key);
    tick_res_t        r;
    int               slot;
    int               sat;
    logic [COUNT_W:0] next_press;
    logic [TICK_W:0]  next_lock;
    r = QUIET;
    slot = NUM_KEYS;
    if (!m_locked) begin
      sat = 0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        // a counter above a lowered keep level snaps down and counts as full
        if (m_spc[i] >= m_keep) begin
          m_spc[i] = m_keep;
          sat++;
        end else begin
          m_spc[i] = m_spc[i] + 1'b1;
        end
      end
      if (sat == NUM_KEYS) m_press = '0;
      // the no-key value never matches, lowest matching slot wins
      if (key != NO_KEY) begin
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
          if (m_code[i] == key) slot = i;
        end
      end
      if (slot < NUM_KEYS && m_spc[slot] > m_space) begin
        next_press = {1'b0, m_press} + 1'b1;
        m_spc[slot] = '0;
        if (next_press > {1'b0, m_limit}) begin
          m_press      = '0;
          m_locked     = 1'b1;
          m_lock_cnt   = '0;
          r.busy_start = 1'b1;
        end else begin
          m_press    = next_press[COUNT_W-1:0];
          r.accepted = 1'b1;
          r.key_out  = key;
        end
      end
    end else begin
      // locked: key ignored, spacing counters hold
      next_lock = {1'b0, m_lock_cnt} + 1'b1;
      if (next_lock > {1'b0, m_lock}) begin
        m_locked   = 1'b0;
        m_lock_cnt = '0;
        r.busy_end = 1'b1;
      end else begin
        m_lock_cnt = next_lock[TICK_W-1:0];
      end
    end
    return r;
  endfunction

  // mostly table keys, some near misses, idle polls and random noise
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(99);
    k = m_code[$urandom_range(NUM_KEYS - 1)];
    if (roll < 60) return k;
    if (roll < 70) return k ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
    if (roll < 85) return NO_KEY;
    return $urandom();
  endfunction

  // stop sending and wait until every pending result has come back
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tick_exp_q.size() != 0);
  endtask

  // register writes only go out while the filter is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    wait_drained();
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk_i); while (!(reg_ch.valid && reg_ch.ready));
    apply_reg_write(idx, val);
    reg_ch.valid <= 1'b0;
  endtask

  // offers one tick, with random gaps before it in the sending idle modes
  task automatic send_tick(input logic [KEY_W-1:0] key, input bit typed, input tick_res_t want);
    tick_res_t pred;
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 71) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 12)) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.key_value <= key;
    do @(posedge clk_i); while (!(tick_ch.valid && tick_ch.ready));
    pred = filter_tick(key);
    tick_exp_q.push_back(typed ? want : pred);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: res_ch.ready <= ($urandom_range(99) >= 71);
      IDLE_BOTH: res_ch.ready <= ($urandom_range(99) >= 12);
      default:   res_ch.ready <= 1'b1;
    endcase
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin
    tick_res_t want;
    tick_res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.accepted, res_ch.key_out, res_ch.busy_start, res_ch.busy_end};
      if (tick_exp_q.size() == 0) begin
        $display("%0t: unexpected result acc=%0b key=%h start=%0b end=%0b", $time,
                 got.accepted, got.key_out, got.busy_start, got.busy_end);
        failed = 1'b1;
      end else begin
        want = tick_exp_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected acc=%0b key=%h start=%0b end=%0b", $time,
                   want.accepted, want.key_out, want.busy_start, want.busy_end);
          $display("%0t:          actual   acc=%0b key=%h start=%0b end=%0b", $time,
                   got.accepted, got.key_out, got.busy_start, got.busy_end);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clk_i     = 1'b0;
    failed    = 1'b0;
    idle_mode = IDLE_NONE;
    rst_ni            <= 1'b0;
    tick_ch.valid     <= 1'b0;
    tick_ch.key_value <= NO_KEY;
    reg_ch.valid      <= 1'b0;
    reg_ch.index      <= REG_KEY_CODE_0;
    reg_ch.data       <= '0;

    // predictor starts from the reset state
    for (int i = 0; i < NUM_KEYS; i++) begin
      m_code[i] = NO_KEY;
      m_spc[i]  = '0;
    end
    m_space    = SPACE_TICKS_RST;
    m_keep     = KEEP_TICKS_RST;
    m_lock     = LOCK_TICKS_RST;
    m_limit    = COUNT_LIMIT_RST;
    m_press    = '0;
    m_locked   = 1'b0;
    m_lock_cnt = '0;

    dir_tab = '{
      // after reset the table holds only the no-key code
      '{ROW_TICK,  REG_KEY_CODE_0, NO_KEY,        1'b1, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b1, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'hFFFF_FFFE, 1'b1, QUIET},
      // slot 1 holds the no-key code, slots 2 and 3 share a code
      '{ROW_WRITE, REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_WRITE, REG_KEY_CODE_1, NO_KEY,        1'b0, QUIET},
      '{ROW_WRITE, REG_KEY_CODE_2, KEY_A,         1'b0, QUIET},
      '{ROW_WRITE, REG_KEY_CODE_3, KEY_A,         1'b0, QUIET},
      '{ROW_WRITE, REG_SPACE,      32'd0,         1'b0, QUIET},
      '{ROW_WRITE, REG_KEEP,       32'd2,         1'b0, QUIET},
      '{ROW_WRITE, REG_LOCK,       32'd0,         1'b0, QUIET},
      '{ROW_WRITE, REG_LIMIT,      32'd0,         1'b0, QUIET},
      // zero presses allowed: first pass locks, zero-length lock ends next tick
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b1, LOCK_BEG},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b1, LOCK_DONE},
      '{ROW_TICK,  REG_KEY_CODE_0, NO_KEY,        1'b1, QUIET},
      '{ROW_WRITE, REG_LIMIT,      32'd254,       1'b0, QUIET},
      '{ROW_WRITE, REG_SPACE,      32'd1,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, KEY_A,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h1234_5678, 1'b0, QUIET},
      '{ROW_WRITE, REG_KEEP,       32'd65535,     1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, KEY_A,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, NO_KEY,        1'b0, QUIET},
      // keep lowered below the running counters
      '{ROW_WRITE, REG_KEEP,       32'd0,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_WRITE, REG_SPACE,      32'd65535,     1'b0, QUIET},
      '{ROW_WRITE, REG_KEEP,       32'd65535,     1'b0, QUIET},
      '{ROW_WRITE, REG_LOCK,       32'd65534,     1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, KEY_A,         1'b0, QUIET},
      // writes past the register file
      '{ROW_WRITE, REG_NONE_LO,    32'd0,         1'b0, QUIET},
      '{ROW_WRITE, REG_NONE_HI,    32'hFFFF_FFFF, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      // one press allowed, short lock
      '{ROW_WRITE, REG_LOCK,       32'd2,         1'b0, QUIET},
      '{ROW_WRITE, REG_SPACE,      32'd0,         1'b0, QUIET},
      '{ROW_WRITE, REG_LIMIT,      32'd1,         1'b0, QUIET},
      '{ROW_WRITE, REG_KEEP,       32'd1,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, KEY_A,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, KEY_A,         1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, NO_KEY,        1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET},
      '{ROW_TICK,  REG_KEY_CODE_0, 32'h0000_0000, 1'b0, QUIET}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_tick(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random settings with small tick values so lockouts come often
    for (int ph = 0; ph < 10; ph++) begin
      idle_mode = idle_e'(ph % 4);
      for (int s = 0; s < NUM_KEYS; s++) begin
        write_reg(CFG_IDX_W'(REG_KEY_CODE_0 + s),
                  ($urandom_range(9) == 0) ? NO_KEY :
                  ($urandom_range(2) == 0) ? KEY_W'($urandom_range(7)) : KEY_W'($urandom()));
      end
      write_reg(REG_SPACE, $urandom_range(6));
      write_reg(REG_KEEP,  $urandom_range(20));
      write_reg(REG_LOCK,  $urandom_range(30));
      write_reg(REG_LIMIT, $urandom_range(8));
      write_reg(REG_NONE_LO + CFG_IDX_W'($urandom_range(7)), $urandom());
      repeat (40) send_tick(pick_key(), 1'b0, QUIET);
    end

    // fresh distinct codes for the corner settings
    for (int s = 0; s < NUM_KEYS; s++) begin
      write_reg(CFG_IDX_W'(REG_KEY_CODE_0 + s), {(KEY_W-2)'($urandom()), 2'(s)});
    end

    // spacing can never be exceeded: nothing passes
    idle_mode = IDLE_BOTH;
    write_reg(REG_SPACE, 32'd65535);
    write_reg(REG_KEEP,  32'd65535);
    write_reg(REG_LIMIT, 32'd254);
    write_reg(REG_LOCK,  32'd0);
    repeat (40) send_tick(pick_key(), 1'b0, QUIET);

    // counters never saturate, so the press count climbs toward the top limit
    idle_mode = IDLE_RECV;
    write_reg(REG_SPACE, 32'd0);
    write_reg(REG_LOCK,  32'd3);
    repeat (400) send_tick(pick_key(), 1'b0, QUIET);

    // keep at zero holds every counter at zero: press count always cleared
    idle_mode = IDLE_SEND;
    write_reg(REG_KEEP,  32'd0);
    write_reg(REG_LIMIT, 32'd0);
    repeat (20) send_tick(pick_key(), 1'b0, QUIET);

    // near-longest lockout: its start and the held ticks after it, back to back
    idle_mode = IDLE_NONE;
    write_reg(REG_KEEP, 32'd1);
    write_reg(REG_LOCK, 32'd65534);
    repeat (20) send_tick(m_code[0], 1'b0, QUIET);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (!failed && tick_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> per_key_rate_filter_with_lockout.f
src/pkrf_pkg.sv
src/pkrf_ifs.sv
src/pkrf_cell.sv
src/pkrf_lock.sv
src/per_key_rate_filter_with_lockout.sv
tb/testbench.sv
